// ===== rtl/decode_batch_steering_age_cap_assert.svh =====
// assertion macros for the decode batch steering block
// used by the top level only; no other dependencies
`ifndef DECODE_BATCH_STEERING_AGE_CAP_ASSERT_SVH
`define DECODE_BATCH_STEERING_AGE_CAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DBSAC_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define DBSAC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`define DBSAC_ASSERT_RESET(lbl, ck, cons, msg) \
  lbl: assert property (@(posedge ck) (1'b1) |=> (cons)) else $error(msg);
`else
`define DBSAC_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg)
`define DBSAC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`define DBSAC_ASSERT_RESET(lbl, ck, cons, msg)
`endif
`endif

// ===== rtl/dbsac_pkg.sv =====
// shared types and constants for the decode batch steering block
// no dependencies
`timescale 1ns / 1ps
package dbsac_pkg;

  localparam int IDX_W      = 10;
  localparam int RESULT_CAP = 64;

  // item kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_CLEAR   = 2'd1;
  localparam logic [1:0] KIND_COMPOSE = 2'd2;
  localparam logic [1:0] KIND_AGE     = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_COUNT_TARGET = 2'd0;
  localparam logic [1:0] CFG_KV_TARGET    = 2'd1;
  localparam logic [1:0] CFG_AGE_CAP      = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  entry_index;
    logic        present;
    logic [19:0] kv_len;
    logic [15:0] wait_age;
  } req_t;

  typedef struct packed {
    logic [5:0]  picked_index;
    logic [19:0] picked_kv_length;
    logic        age_forced;
    logic [31:0] running_kv_sum;
    logic        last;
    logic        no_pick;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_present;
    logic [19:0]      wr_kv;
    logic [15:0]      wr_wait;
    logic             clr_used;
    logic             clr_picked;
    logic             age;
    logic             pick_en;
    logic [IDX_W-1:0] pick_idx;
    logic [6:0]       d;
    logic [31:0]      rem;
    logic [15:0]      age_cap;
  } cmd_t;

  // best-so-far token passed along the chain
  typedef struct packed {
    logic             live;
    logic             f_valid;
    logic [15:0]      f_wait;
    logic [IDX_W-1:0] f_idx;
    logic [19:0]      f_kv;
    logic             n_valid;
    logic [31:0]      n_dist;
    logic [IDX_W-1:0] n_idx;
    logic [19:0]      n_kv;
  } tok_t;

endpackage

// ===== rtl/decode_batch_steering_age_cap.sv =====
// Decode batch steering with an age cap: top level.
// Channels: req (valid/ready, one req_t beat per item) and rsp (valid/ready,
// one rsp_t beat per pick). Configuration through cfg_we/cfg_addr/cfg_wdata,
// to be written by the user only while the block is idle (the block does not
// enforce this); index 0 count target, 1 KV target, 2 age cap.
// Write, clear and age items return no beat and leave req_ready high.
// A compose item returns one beat per pick (last set on the final one), or a
// single no_pick beat for an empty batch. Each pick is one scan of the slot
// chain: the best-so-far token walks one cell a cycle. req_ready stays low
// for the batch. Each beat is held until the previous pick is known not to be
// the last. A stalled rsp holds the next beat and pauses the batch loop at
// its next result; nothing is dropped.
// Reset (synchronous, rst high) empties every slot and clears all marks,
// count and KV targets go to 0, age cap to 65535.
// depends on dbsac_pkg, dbsac_cell, dbsac_ctrl, assertion macro header
`timescale 1ns / 1ps
`include "decode_batch_steering_age_cap_assert.svh"
module decode_batch_steering_age_cap import dbsac_pkg::*; #(
  parameter int POOL_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  cmd_t cmd;
  tok_t tok [POOL_ENTRIES+1];

  // sequencer
  dbsac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .tok_start (tok[0]),
    .tok_end   (tok[POOL_ENTRIES])
  );

  // slot chain
  for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
    dbsac_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // checks
  `DBSAC_ASSERT_NEXT(a_compose_busy, clk, rst, req_valid && req_ready && req.kind == KIND_COMPOSE, !req_ready, "compose did not block new items")
  `DBSAC_ASSERT_IMPL(a_no_pick_zero, clk, rst, rsp_valid && rsp.no_pick, !rsp.last && rsp.running_kv_sum == 32'd0 && rsp.picked_kv_length == 20'd0 && !rsp.age_forced, "empty batch beat has nonzero fields")
  `DBSAC_ASSERT_RESET(a_reset_idle, clk, !$past(rst) || (!rsp_valid && req_ready), "block not idle after reset")

endmodule

// ===== rtl/dbsac_cell.sv =====
// one request slot of the table plus its stage of the selection chain
// depends on dbsac_pkg
`timescale 1ns / 1ps
module dbsac_cell import dbsac_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  tok_t tok_in,
  output tok_t tok_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [19:0] kv;
  logic [15:0] wt;
  logic        present;
  logic        used;
  logic        picked;
  logic [31:0] gap_len;
  logic [26:0] scaled;
  logic        cand;
  logic        f_take;
  logic        n_take;
  tok_t        tok_next;

  // distance to the ideal length, registered ahead of the token
  assign scaled = 27'(kv) * 27'(cmd.d);

  // merge own candidacy into the passing token
  assign cand   = present && !used;
  assign f_take = cand && (wt >= cmd.age_cap) && (!tok_in.f_valid || wt > tok_in.f_wait);
  assign n_take = cand && (!tok_in.n_valid || gap_len < tok_in.n_dist);

  always_comb begin
    tok_next = tok_in;
    if (f_take) begin
      tok_next.f_valid = 1'b1;
      tok_next.f_wait  = wt;
      tok_next.f_idx   = MY_IDX;
      tok_next.f_kv    = kv;
    end
    if (n_take) begin
      tok_next.n_valid = 1'b1;
      tok_next.n_dist  = gap_len;
      tok_next.n_idx   = MY_IDX;
      tok_next.n_kv    = kv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present      <= 1'b0;
      used         <= 1'b0;
      picked       <= 1'b0;
      kv           <= '0;
      wt           <= '0;
      tok_out.live <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (cmd.wr_en && cmd.wr_idx == MY_IDX) begin
        present <= cmd.wr_present;
        kv      <= cmd.wr_kv;
        wt      <= cmd.wr_wait;
        used    <= 1'b0;
        picked  <= 1'b0;
      end else begin
        if (cmd.clr_used) used <= 1'b0;
        if (cmd.clr_picked) picked <= 1'b0;
        if (cmd.pick_en && cmd.pick_idx == MY_IDX) begin
          used   <= 1'b1;
          picked <= 1'b1;
        end
        // aging: picked slots restart, others count up and saturate
        if (cmd.age && present) begin
          if (picked) wt <= '0;
          else if (wt != 16'hFFFF) wt <= wt + 16'd1;
        end
      end
    end
    gap_len <= (32'(scaled) >= cmd.rem) ? 32'(scaled) - cmd.rem : cmd.rem - 32'(scaled);
  end

endmodule

// ===== rtl/dbsac_ctrl.sv =====
// sequencer: registers, item decode, batch loop, pending pick and result register
// depends on dbsac_pkg
`timescale 1ns / 1ps
module dbsac_ctrl import dbsac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output cmd_t        cmd,
  output tok_t        tok_start,
  input  tok_t        tok_end
);

  typedef enum logic [2:0] {IDLE, CHECK, PREP, LAUNCH, SCAN, RESULT, FIN} state_t;

  state_t      state;
  logic [6:0]  batch_cap;
  logic [31:0] kv_goal;
  logic [15:0] age_cap;
  logic [6:0]  n;
  logic [32:0] sum;
  logic [6:0]  d;
  logic [31:0] rem;
  tok_t        res;
  logic        pend_valid;
  logic [IDX_W-1:0] pend_idx;
  logic [19:0] pend_kv;
  logic        pend_forced;
  logic [31:0] pend_sum;

  logic        accept;
  logic        out_free;
  logic        pick_any;
  logic        commit;
  logic        go_on;
  logic        rsp_load;
  logic [IDX_W-1:0] sel_idx;
  logic [19:0] sel_kv;
  logic [32:0] sum_next;

  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign pick_any  = res.f_valid || res.n_valid;
  assign sel_idx   = res.f_valid ? res.f_idx : res.n_idx;
  assign sel_kv    = res.f_valid ? res.f_kv : res.n_kv;
  assign commit    = (state == RESULT) && pick_any && (!pend_valid || out_free);
  assign sum_next  = sum + 33'(sel_kv);
  assign go_on     = (n < 7'(RESULT_CAP)) && (n < batch_cap) && (sum < {1'b0, kv_goal});
  assign rsp_load  = (commit && pend_valid) || ((state == FIN) && out_free);

  // broadcast to the cells
  always_comb begin
    cmd            = '0;
    cmd.wr_en      = accept && req.kind == KIND_WRITE;
    cmd.wr_idx     = IDX_W'(req.entry_index);
    cmd.wr_present = req.present;
    cmd.wr_kv      = req.kv_len;
    cmd.wr_wait    = req.wait_age;
    cmd.clr_used   = accept && req.kind == KIND_CLEAR;
    cmd.clr_picked = accept && req.kind == KIND_COMPOSE;
    cmd.age        = accept && req.kind == KIND_AGE;
    cmd.pick_en    = commit;
    cmd.pick_idx   = sel_idx;
    cmd.d          = d;
    cmd.rem        = rem;
    cmd.age_cap    = age_cap;
  end

  // empty token enters the chain
  always_comb begin
    tok_start      = '0;
    tok_start.live = (state == LAUNCH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      batch_cap  <= '0;
      kv_goal    <= '0;
      age_cap    <= 16'hFFFF;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_COUNT_TARGET: batch_cap <= cfg_wdata[6:0];
          CFG_KV_TARGET:    kv_goal   <= cfg_wdata;
          CFG_AGE_CAP:      age_cap   <= cfg_wdata[15:0];
          default:          ;
        endcase
      end
      // result register handshake
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept && req.kind == KIND_COMPOSE) begin
            n     <= '0;
            sum   <= '0;
            state <= CHECK;
          end
        end
        CHECK: begin
          d     <= batch_cap - n;
          rem   <= 32'({1'b0, kv_goal} - sum);
          state <= go_on ? PREP : FIN;
        end
        PREP:   state <= LAUNCH;
        LAUNCH: state <= SCAN;
        SCAN: begin
          if (tok_end.live) begin
            res   <= tok_end;
            state <= RESULT;
          end
        end
        RESULT: begin
          if (!pick_any) begin
            state <= FIN;
          end else if (commit) begin
            // earlier pick is now known not to be the final one
            if (pend_valid) begin
              rsp.picked_index     <= 6'(pend_idx);
              rsp.picked_kv_length <= pend_kv;
              rsp.age_forced       <= pend_forced;
              rsp.running_kv_sum   <= pend_sum;
              rsp.last             <= 1'b0;
              rsp.no_pick          <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_idx    <= sel_idx;
            pend_kv     <= sel_kv;
            pend_forced <= res.f_valid;
            pend_sum    <= sum_next[31:0];
            sum         <= sum_next;
            n           <= n + 7'd1;
            state       <= CHECK;
          end
        end
        FIN: begin
          if (out_free) begin
            rsp.picked_index     <= pend_valid ? 6'(pend_idx) : 6'd0;
            rsp.picked_kv_length <= pend_valid ? pend_kv : 20'd0;
            rsp.age_forced       <= pend_valid && pend_forced;
            rsp.running_kv_sum   <= pend_valid ? pend_sum : 32'd0;
            rsp.last             <= pend_valid;
            rsp.no_pick          <= !pend_valid;
            pend_valid           <= 1'b0;
            state                <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
